// File: src/lict_pkg.sv
package lict_pkg;

    // Table geometry
    localparam int SLOTS      = 8;
    localparam int MAX_FILLED = 127;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STEP_W     = $clog2(SLOTS + 1);

    // Request codes
    typedef enum logic [1:0] {
        ACT_LOCATE   = 2'd0,
        ACT_ALLOCATE = 2'd1,
        ACT_RELEASE  = 2'd2
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } lict_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lict_status_t;

endpackage

// File: src/lict_ctrl.sv
module lict_ctrl
    import lict_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  lict_status_t status,
    output lict_cmd_t    cmd,
    output logic         in_stall
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/lict_datapath.sv
module lict_datapath
    import lict_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lict_cmd_t    cmd,
    output lict_status_t status,
    input  logic [1:0]   action,
    input  logic [31:0]  file_number,
    input  logic [15:0]  lookup_index,
    input  logic [15:0]  start_offset,
    input  logic [2:0]   skip_factor,
    input  logic [2:0]   slot_select,
    input  logic [6:0]   filled_count,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         success,
    output logic [2:0]   slot_number,
    output logic [15:0]  slot_offset,
    output logic [6:0]   slot_count,
    output logic [2:0]   slot_skip
);

    // Slot table
    logic [31:0]       owner_reg [SLOTS];
    logic [15:0]       base_reg  [SLOTS];
    logic [2:0]        skipv_reg [SLOTS];
    logic [6:0]        fill_reg  [SLOTS];
    logic [SLOTS-1:0]  lock_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOT_W-1:0] next_slot_reg;

    // Request word
    logic [1:0]        op_reg;
    logic [31:0]       file_reg;
    logic [15:0]       index_reg;
    logic [15:0]       offs_reg;
    logic [2:0]        skip_reg;
    logic [2:0]        sel_reg;
    logic [6:0]        cnt_reg;

    // Scan state
    logic [SLOT_W-1:0] ptr_reg,  ptr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       thr_reg,  thr_next;
    logic              hit_reg,  hit_next;
    logic [SLOT_W-1:0] found_reg, found_next;
    logic [15:0]       f_offs_reg, f_offs_next;
    logic [6:0]        f_cnt_reg,  f_cnt_next;
    logic [2:0]        f_skip_reg, f_skip_next;

    // Result word
    logic              out_valid_reg, out_valid_next;
    logic              success_reg;
    logic [2:0]        slot_number_reg;
    logic [15:0]       slot_offset_reg;
    logic [6:0]        slot_count_reg;
    logic [2:0]        slot_skip_reg;

    logic [SLOT_W-1:0] sel_idx;
    logic              sel_ok;
    logic [SLOT_W-1:0] rd_addr;
    logic [31:0]       rd_owner;
    logic [15:0]       rd_base;
    logic [2:0]        rd_skip;
    logic [6:0]        rd_fill;
    logic              rd_lock;
    logic              rd_valid;
    logic              loc_match;
    logic              alloc_free;
    logic              step_last;
    logic [6:0]        sat_cnt;

    assign sel_idx = SLOT_W'(sel_reg);
    assign sel_ok  = (32'(sel_reg) < SLOTS);
    assign sat_cnt = (32'(cnt_reg) > MAX_FILLED) ? 7'(MAX_FILLED) : cnt_reg;

    // Read one slot: the release target in the finish step, else the scan slot
    assign rd_addr  = (op_reg == ACT_RELEASE) ? sel_idx : ptr_reg;
    assign rd_owner = owner_reg[rd_addr];
    assign rd_base  = base_reg[rd_addr];
    assign rd_skip  = skipv_reg[rd_addr];
    assign rd_fill  = fill_reg[rd_addr];
    assign rd_lock  = lock_reg[rd_addr];
    assign rd_valid = valid_reg[rd_addr];

    assign loc_match = rd_valid && !rd_lock && (rd_owner == file_reg) &&
                       (rd_base >= thr_reg) && (rd_base <= index_reg);
    assign alloc_free = !rd_lock;
    assign step_last  = (step_reg == STEP_W'(SLOTS - 1));

    // Status toward the controller
    always_comb
    begin
        status.out_free = !out_valid_reg || !out_stall;
        case (op_reg)
            ACT_LOCATE:   status.scan_done = step_last;
            ACT_ALLOCATE: status.scan_done = step_last || alloc_free;
            default:      status.scan_done = 1'b1;
        endcase
    end

    // Scan registers: capture on load, advance one slot a cycle
    always_comb
    begin
        ptr_next    = ptr_reg;
        step_next   = step_reg;
        thr_next    = thr_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        f_offs_next = f_offs_reg;
        f_cnt_next  = f_cnt_reg;
        f_skip_next = f_skip_reg;
        if (cmd.load)
        begin
            ptr_next  = (action == ACT_ALLOCATE) ? next_slot_reg : '0;
            step_next = '0;
            thr_next  = start_offset;
            hit_next  = 1'b0;
        end
        else if (cmd.step)
        begin
            ptr_next  = (ptr_reg == SLOT_W'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
            step_next = step_reg + 1'b1;
            if (op_reg == ACT_LOCATE && loc_match)
            begin
                hit_next    = 1'b1;
                found_next  = ptr_reg;
                thr_next    = rd_base;
                f_offs_next = rd_base;
                f_cnt_next  = rd_fill;
                f_skip_next = rd_skip;
            end
            else if (op_reg == ACT_ALLOCATE && alloc_free && !hit_reg)
            begin
                hit_next   = 1'b1;
                found_next = ptr_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            step_reg      <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            step_reg      <= step_next;
            ptr_reg       <= ptr_next;
        end
    end

    // Request and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= action;
            file_reg  <= file_number;
            index_reg <= lookup_index;
            offs_reg  <= start_offset;
            skip_reg  <= skip_factor;
            sel_reg   <= slot_select;
            cnt_reg   <= filled_count;
        end
        thr_reg    <= thr_next;
        found_reg  <= found_next;
        f_offs_reg <= f_offs_next;
        f_cnt_reg  <= f_cnt_next;
        f_skip_reg <= f_skip_next;
    end

    // Result word: load on commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            success_reg     <= 1'b0;
            slot_number_reg <= '0;
            slot_offset_reg <= '0;
            slot_count_reg  <= '0;
            slot_skip_reg   <= '0;
            case (op_reg) inside
                ACT_LOCATE, ACT_ALLOCATE:
                begin
                    if (hit_reg)
                    begin
                        success_reg     <= 1'b1;
                        slot_number_reg <= 3'(found_reg);
                        if (op_reg == ACT_LOCATE)
                        begin
                            slot_offset_reg <= f_offs_reg;
                            slot_count_reg  <= f_cnt_reg;
                            slot_skip_reg   <= f_skip_reg;
                        end
                        else
                        begin
                            slot_offset_reg <= offs_reg;
                            slot_skip_reg   <= skip_reg;
                        end
                    end
                end
                ACT_RELEASE:
                begin
                    if (sel_ok)
                    begin
                        success_reg     <= 1'b1;
                        slot_number_reg <= sel_reg;
                        slot_offset_reg <= rd_base;
                        slot_count_reg  <= sat_cnt;
                        slot_skip_reg   <= rd_skip;
                    end
                end
                default:
                begin
                    success_reg <= 1'b0;
                end
            endcase
        end
    end

    // Slot table update on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i] <= '0;
                base_reg[i]  <= '0;
                skipv_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
            lock_reg      <= '0;
            valid_reg     <= '0;
            next_slot_reg <= '0;
        end
        else if (cmd.commit)
        begin
            case (op_reg)
                ACT_LOCATE:
                begin
                    if (hit_reg)
                    begin
                        lock_reg[found_reg] <= 1'b1;
                    end
                end
                ACT_ALLOCATE:
                begin
                    if (hit_reg)
                    begin
                        owner_reg[found_reg] <= file_reg;
                        base_reg[found_reg]  <= offs_reg;
                        skipv_reg[found_reg] <= skip_reg;
                        fill_reg[found_reg]  <= '0;
                        lock_reg[found_reg]  <= 1'b1;
                        valid_reg[found_reg] <= 1'b1;
                        next_slot_reg <= (found_reg == SLOT_W'(SLOTS - 1)) ?
                                         '0 : found_reg + 1'b1;
                    end
                end
                ACT_RELEASE:
                begin
                    if (sel_ok)
                    begin
                        lock_reg[sel_idx] <= 1'b0;
                        fill_reg[sel_idx] <= sat_cnt;
                    end
                end
                default:
                begin
                    lock_reg <= lock_reg;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign slot_number = slot_number_reg;
    assign slot_offset = slot_offset_reg;
    assign slot_count  = slot_count_reg;
    assign slot_skip   = slot_skip_reg;

endmodule

// File: src/locked_index_cache_table_top.sv
// Sequence: a locate is accepted, then scans all SLOTS slots one slot a cycle, then
// finishes; an allocate stops its scan at the first unlocked slot; a release or an
// unused code ends its scan at once and finishes.
// Throughput: one request at a time; the next is taken as soon as the result
// word sits in the output register, even if it is still stalled.
// Reset (rst_n, asynchronous): all slots cleared, unlocked, invalid; next slot 0.
module locked_index_cache_table_top
    import lict_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] file_number,
    input  logic [15:0] lookup_index,
    input  logic [15:0] start_offset,
    input  logic [2:0]  skip_factor,
    input  logic [2:0]  slot_select,
    input  logic [6:0]  filled_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [2:0]  slot_number,
    output logic [15:0] slot_offset,
    output logic [6:0]  slot_count,
    output logic [2:0]  slot_skip
);

    lict_cmd_t    cmd;
    lict_status_t status;

    lict_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lict_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .file_number  (file_number),
        .lookup_index (lookup_index),
        .start_offset (start_offset),
        .skip_factor  (skip_factor),
        .slot_select  (slot_select),
        .filled_count (filled_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .success      (success),
        .slot_number  (slot_number),
        .slot_offset  (slot_offset),
        .slot_count   (slot_count),
        .slot_skip    (slot_skip)
    );

endmodule
